[sv/adhs_pkg.sv]
// Shared types, constants and helpers for the AML device header scanner.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package adhs_pkg;

  localparam int POSITION_BITS_DEFAULT = 32;
  localparam int LEN_BITS      = 32;
  localparam int WIN_DEPTH     = 10;   // window cells, oldest in cell 0
  localparam int NAME_CHARS    = 4;
  localparam int MIN_HIT_BYTES = 7;    // opcode pair, one length byte, name
  localparam int FLUSH_STEPS   = WIN_DEPTH - MIN_HIT_BYTES;
  localparam int FIFO_DEPTH    = 8;
  localparam int PKG_BITS      = 28;   // widest PkgLength value
  localparam int PADDR_BITS    = 3;

  localparam logic [7:0] EXT_OP_BYTE    = 8'h5B;
  localparam logic [7:0] DEVICE_OP_BYTE = 8'h82;
  localparam logic [7:0] SHORT_LEN_MASK = 8'h3F;
  localparam logic [7:0] LONG_LEN_MASK  = 8'h0F;

  // register index, taken from paddr[2]
  localparam logic [0:0] REG_TABLE_LENGTH = 1'b0;

  // evaluation request travelling down the pipeline
  typedef struct packed {
    logic valid;
    logic done;   // closing word, no window test
    logic last;   // set for the final byte of the table and the flush after it
  } tok_t;

  typedef struct packed {
    logic [31:0] dev_start;
    logic [31:0] dev_end;
    logic [31:0] dev_name;
    logic        scan_done;
    logic        run_end;
  } result_t;

  function automatic logic name_byte_legal(input logic [7:0] c);
    logic upper, digit;
    upper = (c >= 8'h41) && (c <= 8'h5A);
    digit = (c >= 8'h30) && (c <= 8'h39);
    return upper || digit || (c == 8'h5F);
  endfunction

endpackage

`default_nettype wire

[sv/adhs_cell.sv]
// One window cell: a byte, its valid flag and its table position.
// Shifts toward cell 0 on each step. Uses adhs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adhs_cell #(
  parameter int POSITION_BITS = adhs_pkg::POSITION_BITS_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     shift,
  input  wire logic                     clear,
  input  wire logic [7:0]               in_byte,
  input  wire logic                     in_valid,
  input  wire logic [POSITION_BITS-1:0] in_pos,
  input  wire logic [POSITION_BITS:0]   in_s2,
  output logic      [7:0]               byte_q,
  output logic                          valid_q,
  output logic      [POSITION_BITS-1:0] pos_q,
  output logic      [POSITION_BITS:0]   s2_q
);
  import adhs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (clear) begin
      valid_q <= 1'b0;
    end else if (shift) begin
      valid_q <= in_valid;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (shift) begin
      byte_q <= in_byte;
      pos_q  <= in_pos;
      s2_q   <= in_s2;
    end
  end

endmodule

`default_nettype wire

[sv/adhs_eval.sv]
// Two-stage header test of the start held in window cell 0.
// Stage 1: opcode, length, name, lower bound and table length; stage 2: upper bound, end.
// Uses adhs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adhs_eval #(
  parameter int POSITION_BITS = adhs_pkg::POSITION_BITS_DEFAULT
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire adhs_pkg::tok_t                           tok,
  input  wire logic [adhs_pkg::LEN_BITS-1:0]            table_length,
  input  wire logic [adhs_pkg::WIN_DEPTH-1:0][7:0]      win_byte,
  input  wire logic [adhs_pkg::WIN_DEPTH-1:0]           win_valid,
  input  wire logic [POSITION_BITS-1:0]                 win_pos,
  input  wire logic [POSITION_BITS:0]                   win_s2,
  output logic                                          busy,
  output logic                                          res_valid,
  output adhs_pkg::result_t                             res
);
  import adhs_pkg::*;

  localparam int EXT_BITS = LEN_BITS + 1;

  logic [7:0]          lead;
  logic [1:0]          extra;
  logic [7:0]          short_len, long_len;
  logic [PKG_BITS-1:0] pkg;
  logic [31:0]         name;
  logic                hdr_ok, avail_ok, name_ok, low_ok, lt_ok;
  logic [EXT_BITS-1:0] s2x, lenx;

  // stage 1 registers
  tok_t                 e1_tok;
  logic                 e1_ok;
  logic [PKG_BITS-1:0]  e1_pkg;
  logic [EXT_BITS-1:0]  e1_rem;
  logic [EXT_BITS-1:0]  e1_s2;
  logic [31:0]          e1_name;
  logic [POSITION_BITS-1:0] e1_start;

  logic                hit;
  logic [EXT_BITS-1:0] end_sum;

  always_comb begin
    lead      = win_byte[2];
    extra     = lead[7:6];
    short_len = lead & SHORT_LEN_MASK;
    long_len  = lead & LONG_LEN_MASK;
    hdr_ok    = (win_byte[0] == EXT_OP_BYTE) && (win_byte[1] == DEVICE_OP_BYTE);
    // every byte up to the end of the name must be held
    avail_ok  = (&win_valid[MIN_HIT_BYTES-1:0])
                && ((extra == 2'd0) || win_valid[7])
                && ((extra <  2'd2) || win_valid[8])
                && ((extra != 2'd3) || win_valid[9]);
    case (extra)
      2'd0: begin
        pkg  = PKG_BITS'(short_len);
        name = {win_byte[6], win_byte[5], win_byte[4], win_byte[3]};
      end
      2'd1: begin
        pkg  = PKG_BITS'({win_byte[3], long_len[3:0]});
        name = {win_byte[7], win_byte[6], win_byte[5], win_byte[4]};
      end
      2'd2: begin
        pkg  = PKG_BITS'({win_byte[4], win_byte[3], long_len[3:0]});
        name = {win_byte[8], win_byte[7], win_byte[6], win_byte[5]};
      end
      default: begin
        pkg  = {win_byte[5], win_byte[4], win_byte[3], long_len[3:0]};
        name = {win_byte[9], win_byte[8], win_byte[7], win_byte[6]};
      end
    endcase
    name_ok = name_byte_legal(name[7:0]) && name_byte_legal(name[15:8])
              && name_byte_legal(name[23:16]) && name_byte_legal(name[31:24]);
    // package must cover the length bytes and the name
    low_ok  = pkg >= (PKG_BITS'(extra) + PKG_BITS'(1 + NAME_CHARS));
    s2x     = EXT_BITS'(win_s2);
    lenx    = EXT_BITS'(table_length);
    lt_ok   = s2x < lenx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_tok <= '0;
    end else begin
      e1_tok <= tok;
    end
  end

  always_ff @(posedge clk) begin
    e1_ok    <= hdr_ok && avail_ok && name_ok && low_ok && lt_ok;
    e1_pkg   <= pkg;
    e1_rem   <= lenx - s2x;
    e1_s2    <= s2x;
    e1_name  <= name;
    e1_start <= win_pos;
  end

  always_comb begin
    hit     = e1_ok && (EXT_BITS'(e1_pkg) <= e1_rem);
    end_sum = e1_s2 + EXT_BITS'(e1_pkg);
    busy      = e1_tok.valid;
    res_valid = e1_tok.valid && (e1_tok.done || hit);
    if (e1_tok.done) begin
      res = '{dev_start: '0, dev_end: '0, dev_name: '0, scan_done: 1'b1, run_end: 1'b1};
    end else begin
      res.dev_start = 32'(e1_start);
      res.dev_end   = end_sum[31:0];
      res.dev_name  = e1_name;
      res.scan_done = 1'b0;
      res.run_end   = !e1_tok.last;
    end
  end

endmodule

`default_nettype wire

[sv/adhs_fifo.sv]
// Result queue between the test pipeline and the output stream.
// Register array, one write and one read a cycle. Uses adhs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adhs_fifo (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    push,
  input  wire adhs_pkg::result_t                       push_data,
  input  wire logic                                    pop,
  output logic                                         out_valid,
  output adhs_pkg::result_t                            out_data,
  output logic [$clog2(adhs_pkg::FIFO_DEPTH+1)-1:0]    count
);
  import adhs_pkg::*;

  localparam int PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);

  result_t             mem [FIFO_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic                do_pop;

  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign do_pop    = pop && out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      count <= count + CNT_BITS'(push) - CNT_BITS'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

[sv/aml_device_header_scan.sv]
// AML Device header scanner: a result word is queued, m_tvalid high, once
// the byte that completes its test has passed the window, the stage 1
// registers and the queue. Throughput one table byte per cycle while the
// queue has room; the header test advances every cycle. The final byte adds
// a flush with s_tready low: 3 shifts of empty cells, then the done word.
// Reset (rst, synchronous): empties window and queue, position and length to 0.
`timescale 1ns / 1ps
`default_nettype none

module aml_device_header_scan #(
  parameter int POSITION_BITS = adhs_pkg::POSITION_BITS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // byte stream in
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [7:0]                        s_tdata,   // [7:0] table_byte
  input  wire logic                              s_tlast,   // final_byte
  // result stream out
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [95:0]                            m_tdata,   // [31:0] device_start,
                                                            // [63:32] device_end,
                                                            // [95:64] device_name
  output logic [0:0]                             m_tuser,   // [0] scan_done
  output logic                                   m_tlast,   // run_end
  // configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [adhs_pkg::PADDR_BITS-1:0]   paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);
  import adhs_pkg::*;

  localparam int WD        = WIN_DEPTH;
  localparam int CNT_BITS  = $clog2(FIFO_DEPTH + 1);
  localparam int FLUSH_BITS = $clog2(FLUSH_STEPS + 1);

  // Window chain: element WD is the entry point, cells 0..WD-1 hold the window.
  logic [WD:0][7:0]                chain_byte;
  logic [WD:0]                     chain_valid;
  logic [WD:0][POSITION_BITS-1:0]  chain_pos;
  logic [WD:0][POSITION_BITS:0]    chain_s2;

  logic [LEN_BITS-1:0]      table_length;
  logic [POSITION_BITS-1:0] position;       // position of the next byte
  logic                     flushing;
  logic [FLUSH_BITS-1:0]    flush_left;
  tok_t                     t0;             // test request for cell 0

  logic                s_accept, room, step, bubble, done_step, shift;
  logic [CNT_BITS-1:0] occ, fifo_count;
  logic                e1_busy, res_valid;
  result_t             res, head;

  // Every request in flight may turn into one queued word, so requests are
  // issued only while the queue has room for all of them.
  assign occ       = fifo_count + CNT_BITS'(t0.valid) + CNT_BITS'(e1_busy);
  assign room      = occ < CNT_BITS'(FIFO_DEPTH);
  assign s_tready  = !flushing && room;
  assign s_accept  = s_tvalid && s_tready;
  assign step      = flushing && room;
  assign bubble    = step && (flush_left != '0);
  assign done_step = step && (flush_left == '0);
  assign shift     = s_accept || bubble;

  // entry of the chain: the new byte, or an empty cell during the flush
  assign chain_byte[WD]  = s_tdata;
  assign chain_valid[WD] = s_accept;
  assign chain_pos[WD]   = position;
  assign chain_s2[WD]    = {1'b0, position} + (POSITION_BITS+1)'(2);

  for (genvar i = 0; i < WD; i++) begin : g_cell
    adhs_cell #(.POSITION_BITS(POSITION_BITS)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (shift),
      .clear    (done_step),
      .in_byte  (chain_byte[i+1]),
      .in_valid (chain_valid[i+1]),
      .in_pos   (chain_pos[i+1]),
      .in_s2    (chain_s2[i+1]),
      .byte_q   (chain_byte[i]),
      .valid_q  (chain_valid[i]),
      .pos_q    (chain_pos[i]),
      .s2_q     (chain_s2[i])
    );
  end

  // Control: one test of cell 0 after each shift. After the final byte the
  // chain shifts in empty cells until every start that could still fit a
  // header has passed cell 0, then the done word goes out and the window clears.
  // Accept, bubble and done step never coincide (accept needs !flushing).
  always_ff @(posedge clk) begin
    if (rst) begin
      t0           <= '0;
      position     <= '0;
      flushing     <= 1'b0;
      flush_left   <= '0;
      table_length <= '0;
    end else begin
      if (s_accept) begin
        t0 <= '{valid: 1'b1, done: 1'b0, last: s_tlast};
        if (s_tlast) begin
          position   <= '0;
          flushing   <= 1'b1;
          flush_left <= FLUSH_BITS'(FLUSH_STEPS);
        end else begin
          position <= position + POSITION_BITS'(1);
        end
      end else if (bubble) begin
        t0         <= '{valid: 1'b1, done: 1'b0, last: 1'b1};
        flush_left <= flush_left - FLUSH_BITS'(1);
      end else if (done_step) begin
        t0       <= '{valid: 1'b1, done: 1'b1, last: 1'b1};
        flushing <= 1'b0;
      end else begin
        t0 <= '0;
      end
      if (psel && penable && pwrite && pready && (paddr[2] == REG_TABLE_LENGTH)) begin
        table_length <= pwdata;
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TABLE_LENGTH) ? table_length : '0;

  adhs_eval #(.POSITION_BITS(POSITION_BITS)) u_eval (
    .clk          (clk),
    .rst          (rst),
    .tok          (t0),
    .table_length (table_length),
    .win_byte     (chain_byte[WD-1:0]),
    .win_valid    (chain_valid[WD-1:0]),
    .win_pos      (chain_pos[0]),
    .win_s2       (chain_s2[0]),
    .busy         (e1_busy),
    .res_valid    (res_valid),
    .res          (res)
  );

  adhs_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .pop       (m_tready),
    .out_valid (m_tvalid),
    .out_data  (head),
    .count     (fifo_count)
  );

  assign m_tdata = {head.dev_name, head.dev_end, head.dev_start};
  assign m_tuser = head.scan_done;
  assign m_tlast = head.run_end;

endmodule

`default_nettype wire
